// ===== rtl/pec_pkg.sv =====
// Shared constants, types and helper functions for the pretrigger event capture block.
`default_nettype none

package pec_pkg;

	localparam int DATA_W     = 16;
	localparam int PRE_DEPTH  = 32;   // power of two: ring wrap and mean use shifts
	localparam int PRE_AW     = $clog2(PRE_DEPTH);
	localparam int EVT_DEPTH  = 256;  // power of two, larger than PRE_DEPTH
	localparam int EVT_AW     = $clog2(EVT_DEPTH);
	localparam int SUM_W      = DATA_W + PRE_AW;
	localparam int MODE_W     = 2;
	localparam int IDX_W      = 8;
	localparam int WIN_W      = 8;
	localparam int CFG_AW     = 4;
	localparam int APB_DW     = 32;
	localparam int IN_DATA_W  = 24;
	localparam int IN_PAD_W   = IN_DATA_W - DATA_W - IDX_W;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_PAD_W  = OUT_DATA_W - 2 - 2 * DATA_W;

	localparam logic [DATA_W-1:0] JERK_TH_RST  = 16'd1000;
	localparam logic [DATA_W-1:0] LEVEL_TH_RST = 16'd1000;
	localparam logic [DATA_W-1:0] CONF_TH_RST  = 16'd500;
	localparam logic [WIN_W-1:0]  CONF_WIN_RST = 8'd16;

	typedef enum logic [MODE_W-1:0] {
		MODE_FEED    = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_READ    = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_JERK_TH  = 2'd0,
		REG_LEVEL_TH = 2'd1,
		REG_CONF_TH  = 2'd2,
		REG_CONF_WIN = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_FINISH,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] jerk_th;
		logic [DATA_W-1:0] level_th;
		logic [DATA_W-1:0] conf_th;
		logic [WIN_W-1:0]  conf_win;
	} cfg_t;

	// Commands from the sequencer to the history ring.
	typedef struct packed {
		logic              rd_en;
		logic [PRE_AW-1:0] rd_off;
		logic              acc;   // account a sample: sum, fill, last sample
		logic              wr;    // write sample at pointer and advance
		logic [DATA_W-1:0] smp;
	} hist_cmd_t;

	// Status from the history ring.
	typedef struct packed {
		logic              full;
		logic              have_last;
		logic [DATA_W-1:0] last;
		logic [DATA_W-1:0] baseline;
		logic [DATA_W-1:0] rd_data;
	} hist_t;

	typedef struct packed {
		logic              ready_res;
		logic              collecting;
		logic [DATA_W-1:0] read_sample;
		logic [DATA_W-1:0] peak_abs;
	} res_t;

	// Magnitude of a two's complement sample; the most negative value gives 32768.
	function automatic logic [DATA_W-1:0] abs_s(input logic [DATA_W-1:0] a);
		return a[DATA_W-1] ? (~a + 1'b1) : a;
	endfunction

	// Magnitude of the difference of two samples; fits DATA_W bits unsigned.
	function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W:0] d;
		logic [DATA_W:0] m;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		m = d[DATA_W] ? (~d + 1'b1) : d;
		return m[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pec_cfg.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module pec_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pec_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [pec_pkg::APB_DW-1:0]  pwdata,
	output logic      [pec_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output pec_pkg::cfg_t                    cfg
);

	pec_pkg::cfg_t    cfg_q;
	pec_pkg::reg_idx_t reg_idx;
	logic             wr_en;

	assign reg_idx = pec_pkg::reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jerk_th  <= pec_pkg::JERK_TH_RST;
			cfg_q.level_th <= pec_pkg::LEVEL_TH_RST;
			cfg_q.conf_th  <= pec_pkg::CONF_TH_RST;
			cfg_q.conf_win <= pec_pkg::CONF_WIN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				pec_pkg::REG_JERK_TH:  cfg_q.jerk_th  <= pwdata[pec_pkg::DATA_W-1:0];
				pec_pkg::REG_LEVEL_TH: cfg_q.level_th <= pwdata[pec_pkg::DATA_W-1:0];
				pec_pkg::REG_CONF_TH:  cfg_q.conf_th  <= pwdata[pec_pkg::DATA_W-1:0];
				pec_pkg::REG_CONF_WIN: cfg_q.conf_win <= pwdata[pec_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pec_pkg::REG_JERK_TH:  prdata = pec_pkg::APB_DW'(cfg_q.jerk_th);
			pec_pkg::REG_LEVEL_TH: prdata = pec_pkg::APB_DW'(cfg_q.level_th);
			pec_pkg::REG_CONF_TH:  prdata = pec_pkg::APB_DW'(cfg_q.conf_th);
			pec_pkg::REG_CONF_WIN: prdata = pec_pkg::APB_DW'(cfg_q.conf_win);
			default:               prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/pec_hist.sv =====
// Pretrigger history ring: sample memory, pointer, fill count and running sum.
`default_nettype none

module pec_hist (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  pec_pkg::hist_cmd_t      cmd,
	output pec_pkg::hist_t          st
);

	logic [pec_pkg::DATA_W-1:0] ring [pec_pkg::PRE_DEPTH];
	logic [pec_pkg::DATA_W-1:0] rd_data_q;
	logic [pec_pkg::PRE_AW-1:0] ptr_q;
	logic [pec_pkg::PRE_AW:0]   fill_q;
	logic [pec_pkg::SUM_W-1:0]  sum_q;
	logic [pec_pkg::DATA_W-1:0] last_q;
	logic                       have_last_q;

	logic [pec_pkg::PRE_AW-1:0] rd_addr;
	logic                       full;
	logic [pec_pkg::SUM_W-1:0]  old_ext;
	logic [pec_pkg::SUM_W-1:0]  smp_ext;
	logic [pec_pkg::SUM_W-1:0]  bias;
	logic [pec_pkg::SUM_W-1:0]  adj;

	assign rd_addr = ptr_q + cmd.rd_off;
	assign full    = (fill_q == (pec_pkg::PRE_AW + 1)'(pec_pkg::PRE_DEPTH));

	// The entry under the pointer was read at accept; it leaves the sum once the ring is full.
	assign old_ext = full ? {{pec_pkg::PRE_AW{rd_data_q[pec_pkg::DATA_W-1]}}, rd_data_q} : '0;
	assign smp_ext = {{pec_pkg::PRE_AW{cmd.smp[pec_pkg::DATA_W-1]}}, cmd.smp};

	// Mean truncated toward zero: bias negative sums before the shift.
	assign bias = sum_q[pec_pkg::SUM_W-1] ? pec_pkg::SUM_W'(pec_pkg::PRE_DEPTH - 1) : '0;
	assign adj  = sum_q + bias;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			ring[ptr_q] <= cmd.smp;
		end
		if (cmd.rd_en) begin
			rd_data_q <= ring[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			last_q      <= '0;
			have_last_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.acc) begin
				sum_q       <= sum_q - old_ext + smp_ext;
				last_q      <= cmd.smp;
				have_last_q <= 1'b1;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	assign st.full      = full;
	assign st.have_last = have_last_q;
	assign st.last      = last_q;
	assign st.baseline  = adj[pec_pkg::SUM_W-1:pec_pkg::PRE_AW];
	assign st.rd_data   = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/pec_core.sv =====
// Item sequencer with the event store memory and the event state registers.
`default_nettype none

module pec_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  pec_pkg::cfg_t                    cfg,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [pec_pkg::MODE_W-1:0]  in_mode,
	input  wire logic [pec_pkg::DATA_W-1:0]  in_sample,
	input  wire logic [pec_pkg::IDX_W-1:0]   in_index,
	input  wire logic                        out_free,
	output logic                             res_valid,
	output pec_pkg::res_t                    res,
	output pec_pkg::hist_cmd_t               hcmd,
	input  pec_pkg::hist_t                   hist
);

	localparam int FILL_W = pec_pkg::EVT_AW + 1;
	localparam int LIM_W  = pec_pkg::EVT_AW + 2;

	logic [pec_pkg::DATA_W-1:0] store [pec_pkg::EVT_DEPTH];
	logic [pec_pkg::DATA_W-1:0] store_rd_q;

	pec_pkg::state_t            state_q, state_d;
	pec_pkg::mode_t             mode_s1;
	logic [pec_pkg::DATA_W-1:0] smp_s1;
	logic [pec_pkg::PRE_AW:0]   cnt_q, cnt_d;
	logic [FILL_W-1:0]          fill_q, fill_d;
	logic [pec_pkg::DATA_W-1:0] peak_q, peak_d;
	logic [pec_pkg::DATA_W-1:0] base_q, base_d;
	logic                       conf_q, conf_d;
	logic                       capt_q, capt_d;
	logic                       held_q, held_d;
	logic [pec_pkg::DATA_W-1:0] rd_q;

	logic                       accept;
	logic                       trig;
	logic                       start;
	logic                       emit;
	logic [pec_pkg::DATA_W-1:0] rd_now;
	logic [pec_pkg::DATA_W-1:0] mag;
	logic [FILL_W-1:0]          fill_inc;
	logic [LIM_W-1:0]           win_lim;
	logic                       st_we;
	logic [pec_pkg::EVT_AW-1:0] st_waddr;
	logic [pec_pkg::DATA_W-1:0] st_wdata;

	assign accept   = in_valid && in_ready;
	assign mag      = pec_pkg::abs_s(smp_s1);
	assign fill_inc = fill_q + 1'b1;
	assign win_lim  = LIM_W'(pec_pkg::PRE_DEPTH) + LIM_W'(cfg.conf_win);

	assign trig = hist.full && hist.have_last
		&& (pec_pkg::abs_diff(smp_s1, hist.last) >= cfg.jerk_th)
		&& (mag >= cfg.level_th);
	assign start = (state_q == pec_pkg::ST_EXEC) && (mode_s1 == pec_pkg::MODE_FEED)
		&& !held_q && !capt_q && trig;

	// Event store: written by the sequencer, read at the index of an accepted item.
	always_ff @(posedge clk) begin
		if (st_we) begin
			store[st_waddr] <= st_wdata;
		end
		if (accept) begin
			store_rd_q <= store[in_index];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pec_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = pec_pkg::ST_EXEC;
				end
			end
			pec_pkg::ST_EXEC: begin
				if (start) begin
					state_d = pec_pkg::ST_SWEEP;
				end else begin
					state_d = out_free ? pec_pkg::ST_IDLE : pec_pkg::ST_WAIT;
				end
			end
			pec_pkg::ST_SWEEP: begin
				if (cnt_q == (pec_pkg::PRE_AW + 1)'(pec_pkg::PRE_DEPTH)) begin
					state_d = pec_pkg::ST_FINISH;
				end
			end
			pec_pkg::ST_FINISH: begin
				state_d = out_free ? pec_pkg::ST_IDLE : pec_pkg::ST_WAIT;
			end
			pec_pkg::ST_WAIT: begin
				if (out_free) begin
					state_d = pec_pkg::ST_IDLE;
				end
			end
			default: state_d = pec_pkg::ST_IDLE;
		endcase
	end

	// Datapath and outputs.
	always_comb begin
		in_ready    = 1'b0;
		hcmd        = '0;
		hcmd.smp    = smp_s1;
		st_we       = 1'b0;
		st_waddr    = '0;
		st_wdata    = smp_s1;
		cnt_d       = '0;
		fill_d      = fill_q;
		peak_d      = peak_q;
		base_d      = base_q;
		conf_d      = conf_q;
		capt_d      = capt_q;
		held_d      = held_q;
		rd_now      = '0;
		emit        = 1'b0;
		case (state_q)
			pec_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				// Fetch the ring entry that the next sample displaces.
				hcmd.rd_en = accept;
			end
			pec_pkg::ST_EXEC: begin
				emit = !start;
				case (mode_s1)
					pec_pkg::MODE_FEED: begin
						if (!held_q) begin
							hcmd.acc = 1'b1;
							if (capt_q) begin
								hcmd.wr  = 1'b1;
								st_we    = !fill_q[FILL_W-1];
								st_waddr = fill_q[pec_pkg::EVT_AW-1:0];
								fill_d   = fill_inc;
								peak_d   = (mag > peak_q) ? mag : peak_q;
								conf_d   = conf_q || (pec_pkg::abs_diff(smp_s1, base_q)
									>= cfg.conf_th);
								if (!conf_d && (LIM_W'(fill_inc) >= win_lim)) begin
									// Drop an event that missed its confirmation window.
									capt_d = 1'b0;
									fill_d = '0;
									peak_d = '0;
								end else if (fill_inc >= FILL_W'(pec_pkg::EVT_DEPTH)) begin
									capt_d = 1'b0;
									held_d = 1'b1;
								end
							end else if (trig) begin
								// Hold the ring write until the sweep has copied it.
								base_d = hist.baseline;
							end else begin
								hcmd.wr = 1'b1;
							end
						end
					end
					pec_pkg::MODE_RELEASE: begin
						held_d = 1'b0;
						conf_d = 1'b0;
						fill_d = '0;
						peak_d = '0;
					end
					pec_pkg::MODE_READ: begin
						rd_now = held_q ? store_rd_q : '0;
					end
					default: ;
				endcase
			end
			pec_pkg::ST_SWEEP: begin
				// Copy the ring oldest first; each entry is written in the cycle after its read.
				hcmd.rd_en  = (cnt_q < (pec_pkg::PRE_AW + 1)'(pec_pkg::PRE_DEPTH));
				hcmd.rd_off = cnt_q[pec_pkg::PRE_AW-1:0];
				st_we       = (cnt_q != '0);
				st_waddr    = pec_pkg::EVT_AW'(cnt_q - 1'b1);
				st_wdata    = hist.rd_data;
				cnt_d       = cnt_q + 1'b1;
			end
			pec_pkg::ST_FINISH: begin
				emit     = 1'b1;
				hcmd.wr  = 1'b1;
				st_we    = 1'b1;
				st_waddr = pec_pkg::EVT_AW'(pec_pkg::PRE_DEPTH);
				fill_d   = FILL_W'(pec_pkg::PRE_DEPTH + 1);
				peak_d   = mag;
				conf_d   = (pec_pkg::abs_diff(smp_s1, base_q) >= cfg.conf_th);
				capt_d   = 1'b1;
			end
			pec_pkg::ST_WAIT: begin
				emit = 1'b1;
			end
			default: ;
		endcase

		res_valid       = emit && out_free;
		res.ready_res   = held_d;
		res.collecting  = capt_d;
		res.read_sample = (state_q == pec_pkg::ST_WAIT) ? rd_q : rd_now;
		res.peak_abs    = peak_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= pec_pkg::mode_t'(in_mode);
			smp_s1  <= in_sample;
		end
		if (state_q != pec_pkg::ST_WAIT) begin
			rd_q <= rd_now;
		end
		base_q <= base_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pec_pkg::ST_IDLE;
			cnt_q   <= '0;
			fill_q  <= '0;
			peak_q  <= '0;
			conf_q  <= 1'b0;
			capt_q  <= 1'b0;
			held_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			fill_q  <= fill_d;
			peak_q  <= peak_d;
			conf_q  <= conf_d;
			capt_q  <= capt_d;
			held_q  <= held_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pretrigger_event_capture.sv =====
// Top level of the pretrigger event capture block: ports, output register, submodules.
//
// Usage: items enter on the s_ group. tuser carries the mode (0 feed a sample, 1 release
// the held event, 2 read one stored event sample, 3 no operation); tdata carries the
// sample and the read index. Every accepted item yields exactly one result item on the
// m_ group: held flag, capturing flag, the read sample (mode 2 while an event is held,
// else zero) and the peak magnitude of the current or held event.
// Thresholds and the confirmation window sit in four APB registers at byte addresses
// 0, 4, 8 and 12; write them only while the block is idle.
// Sequencing: a plain item is accepted, then takes one read-modify-write pass over the
// event state before its result. For a sample that triggers an event, the 32-entry
// history ring is copied into the event memory one entry a cycle through the ring's
// single read port, then the trigger sample is committed.
// One item is in flight at a time; s_tready is high only while the sequencer is idle.
// Reset: thresholds return to their defaults, history and event state clear; the event
// memory contents are not cleared and are only read once a full event is held.
// Stall: results sit in an output register; a new item is accepted while a result waits,
// and the sequencer holds its result until the output register frees up.
`default_nettype none

module pretrigger_event_capture (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// item in
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [pec_pkg::IN_DATA_W-1:0]   s_tdata,  // [15:0] sample, [23:16] read_index
	input  wire logic [pec_pkg::MODE_W-1:0]      s_tuser,  // [1:0] mode
	// item out
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [pec_pkg::OUT_DATA_W-1:0]  m_tdata,  // [0] ready_res, [1] collecting,
	                                                       // [17:2] read_sample,
	                                                       // [33:18] peak_abs, rest zero
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pec_pkg::CFG_AW-1:0]      paddr,
	input  wire logic [pec_pkg::APB_DW-1:0]      pwdata,
	output logic      [pec_pkg::APB_DW-1:0]      prdata,
	output logic                                 pready
);

	pec_pkg::cfg_t      cfg;
	pec_pkg::hist_cmd_t hcmd;
	pec_pkg::hist_t     hist;
	pec_pkg::res_t      res;
	logic               res_valid;
	logic               out_free;

	logic                              m_tvalid_q;
	logic [pec_pkg::OUT_DATA_W-1:0]    m_tdata_q;

	pec_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pec_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hcmd),
		.st     (hist)
	);

	pec_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_sample (s_tdata[pec_pkg::DATA_W-1:0]),
		.in_index  (s_tdata[pec_pkg::DATA_W +: pec_pkg::IDX_W]),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.hcmd      (hcmd),
		.hist      (hist)
	);

	// Output register frees up when empty or drained this cycle.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Pack the result fields, lowest field in the lowest bits.
	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= {{pec_pkg::OUT_PAD_W{1'b0}}, res.peak_abs, res.read_sample,
				res.collecting, res.ready_res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
